[hdl/bitmap_range_engine_macros.svh]
// assertion macros shared by the bitmap range engine rtl
`ifndef BITMAP_RANGE_ENGINE_MACROS_SVH
`define BITMAP_RANGE_ENGINE_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define BRE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bitmap range engine check failed");

// next-cycle implication
`define BRE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bitmap range engine check failed");

`endif

[hdl/bre_pkg.sv]
// shared types and constants of the bitmap range engine
`default_nettype none
package bre_pkg;

    localparam int MAX_BITS_DEF = 4096;
    localparam int WORD_BITS    = 32;
    localparam int BIT_W        = 5;
    localparam int CFG_W        = 13;
    localparam int IDX_W        = 12;
    localparam int ANS_W        = 13;
    localparam int CNT_W        = 6;
    localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

    typedef enum logic [3:0] {
        OP_GET        = 4'd0,
        OP_SET        = 4'd1,
        OP_CLR        = 4'd2,
        OP_RANGE_SET  = 4'd3,
        OP_RANGE_CLR  = 4'd4,
        OP_RANGE_CNT  = 4'd5,
        OP_RUN_LEN    = 4'd6,
        OP_COMPLEMENT = 4'd7,
        OP_CLEAR_ALL  = 4'd8,
        OP_FILL_ALL   = 4'd9,
        OP_NEXT_SET   = 4'd10,
        OP_CURSOR_RST = 4'd11
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_NONE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        K_READ = 3'd0,
        K_SET  = 3'd1,
        K_CLR  = 3'd2,
        K_INV  = 3'd3,
        K_RUN  = 3'd4,
        K_NEXT = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [BIT_W-1:0] lo;
        logic [BIT_W-1:0] hi;
        logic             run_value;
    } t_alu_ctl;

    typedef struct packed {
        logic [WORD_BITS-1:0] new_word;
        logic [CNT_W-1:0]     ones_before;
        logic [CNT_W-1:0]     ones_after;
        logic                 hit;
        logic [BIT_W-1:0]     hit_idx;
    } t_alu_res;

endpackage
`default_nettype wire

[hdl/bre_ram.sv]
// generic single-port-write ram with registered read
`default_nettype none
module bre_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[hdl/bre_word_alu.sv]
// per-word modify, popcount and first-hit search
`default_nettype none
module bre_word_alu (
    input  wire logic [bre_pkg::WORD_BITS-1:0] i_old,
    input  wire bre_pkg::t_alu_ctl             i_ctl,
    output bre_pkg::t_alu_res                  o_res
);
    logic [bre_pkg::WORD_BITS-1:0] mask;
    logic [bre_pkg::WORD_BITS-1:0] hit_vec;
    logic [bre_pkg::WORD_BITS-1:0] new_word;

    function automatic logic [bre_pkg::CNT_W-1:0] popcnt(input logic [31:0] v);
        logic [bre_pkg::CNT_W-1:0] c;
        c = '0;
        for (int i = 0; i < 32; i++) begin
            c = c + bre_pkg::CNT_W'(v[i]);
        end
        return c;
    endfunction

    function automatic logic [bre_pkg::BIT_W-1:0] lowest(input logic [31:0] v);
        logic [bre_pkg::BIT_W-1:0] idx;
        idx = '0;
        for (int i = 31; i >= 0; i--) begin
            if (v[i]) begin
                idx = bre_pkg::BIT_W'(i);
            end
        end
        return idx;
    endfunction

    always_comb begin
        mask = ({32{1'b1}} << i_ctl.lo) & ({32{1'b1}} >> (5'd31 - i_ctl.hi));
        if (i_ctl.kind == bre_pkg::K_RUN) begin
            hit_vec = (i_old ^ {32{i_ctl.run_value}}) & mask;
        end else begin
            hit_vec = i_old & mask;
        end
        unique case (i_ctl.kind)
            bre_pkg::K_SET: new_word = i_old | mask;
            bre_pkg::K_CLR: new_word = i_old & ~mask;
            bre_pkg::K_INV: new_word = i_old ^ mask;
            default:        new_word = i_old;
        endcase
        o_res.new_word    = new_word;
        o_res.ones_before = popcnt(i_old & mask);
        o_res.ones_after  = popcnt(new_word & mask);
        o_res.hit         = |hit_vec;
        o_res.hit_idx     = lowest(hit_vec);
    end
endmodule
`default_nettype wire

[hdl/bitmap_range_engine.sv]
// top level of the bitmap range engine: request sequencer around the word store
//
// channel   | direction | signals
// ----------+-----------+----------------------------------------------------
// request   | in        | start, busy (out), i_operation, i_start_index, i_stop_index,
//           |           | i_run_value
// result    | out       | o_done, o_answer, o_status, o_ones_total
// config    | in        | i_cfg_we, i_cfg_data (bits_in_use)
//
// invalid, cursor-reset and next-with-cursor-past-the-size transactions answer
// in the cycle after acceptance; get, set and clear touch one word, and
// word-walking transactions walk the words of their range in order, with the
// word ram's one read and one write port fetching the next word while the
// current one is written back; the answer is registered after the last word.
// after reset and after each config write a clearing pass writes zero to all
// NWORDS words, one per cycle, with busy high.
// results are strobed by o_done for one cycle; the receiver cannot stall.
`default_nettype none
`include "bitmap_range_engine_macros.svh"
module bitmap_range_engine #(
    parameter int MAX_BITS = bre_pkg::MAX_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [3:0]                i_operation,
    input  wire logic [bre_pkg::IDX_W-1:0] i_start_index,
    input  wire logic [bre_pkg::IDX_W-1:0] i_stop_index,
    input  wire logic                      i_run_value,
    input  wire logic                      i_cfg_we,
    input  wire logic [bre_pkg::CFG_W-1:0] i_cfg_data,
    output logic                           o_done,
    output logic [bre_pkg::ANS_W-1:0]      o_answer,
    output logic [1:0]                     o_status,
    output logic [bre_pkg::CFG_W-1:0]      o_ones_total
);
    localparam int NWORDS = (MAX_BITS + 31) / 32;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int PW     = AW + bre_pkg::BIT_W;
    localparam int CW     = bre_pkg::CFG_W;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_WALK  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0]       r_cfg, n_cfg;
    logic [CW-1:0]       r_ones, n_ones;
    logic [AW:0]         r_cw, n_cw;
    logic [4:0]          r_cb, n_cb;
    logic [AW-1:0]       r_w, n_w;
    logic                r_done, n_done;
    bre_pkg::t_kind      r_kind, n_kind;
    logic [PW-1:0]       r_s, n_s;
    logic [PW-1:0]       r_e, n_e;
    logic                r_rv, n_rv;
    logic [bre_pkg::ANS_W-1:0] r_acc, n_acc;
    logic [bre_pkg::ANS_W-1:0] r_answer, n_answer;
    bre_pkg::t_status    r_status, n_status;

    // store size in effect, and derived limits
    logic [CW-1:0] size;
    logic [CW-1:0] size_m1;
    logic [AW:0]   words;
    logic [AW+5:0] cur_pos;
    logic          pos_bad;
    logic          range_bad;

    // ram and word unit
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [31:0]           ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [31:0]           ram_rdata;
    bre_pkg::t_alu_ctl     alu_ctl;
    bre_pkg::t_alu_res     alu_res;
    logic                  w_last;
    logic [5:0]            run_add;
    logic [PW:0]           hit_next;

    always_comb begin
        if (r_cfg == '0) begin
            size = CW'(1);
        end else if (32'(r_cfg) > MAX_BITS) begin
            size = CW'(MAX_BITS);
        end else begin
            size = r_cfg;
        end
        size_m1   = size - CW'(1);
        words     = (AW+1)'((32'(size) + 32'd31) >> 5);
        cur_pos   = {r_cw, r_cb};
        pos_bad   = {1'b0, i_start_index} >= size;
        range_bad = (i_start_index > i_stop_index) || ({1'b0, i_stop_index} >= size);
    end

    bre_ram #(
        .WIDTH (bre_pkg::WORD_BITS),
        .DEPTH (NWORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // window of the current word inside [r_s, r_e]
    always_comb begin
        alu_ctl.kind      = r_kind;
        alu_ctl.run_value = r_rv;
        alu_ctl.lo        = (r_w == r_s[PW-1:5]) ? r_s[4:0] : 5'd0;
        alu_ctl.hi        = (r_w == r_e[PW-1:5]) ? r_e[4:0] : 5'd31;
        w_last            = (r_w == r_e[PW-1:5]);
        if (alu_res.hit) begin
            run_add = {1'b0, alu_res.hit_idx} - {1'b0, alu_ctl.lo};
        end else begin
            run_add = {1'b0, alu_ctl.hi} - {1'b0, alu_ctl.lo} + 6'd1;
        end
        hit_next = {1'b0, r_w, alu_res.hit_idx} + (PW+1)'(1);
    end

    bre_word_alu u_alu (
        .i_old (ram_rdata),
        .i_ctl (alu_ctl),
        .o_res (alu_res)
    );

    always_comb begin
        n_state   = r_state;
        n_cfg     = r_cfg;
        n_ones    = r_ones;
        n_cw      = r_cw;
        n_cb      = r_cb;
        n_w       = r_w;
        n_done    = 1'b0;
        n_kind    = r_kind;
        n_s       = r_s;
        n_e       = r_e;
        n_rv      = r_rv;
        n_acc     = r_acc;
        n_answer  = r_answer;
        n_status  = r_status;
        ram_we    = 1'b0;
        ram_waddr = r_w;
        ram_wdata = '0;
        ram_raddr = AW'(r_w + AW'(1));

        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                n_w    = r_w + AW'(1);
                if (r_w == AW'(NWORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                // defaults for a word-walking transaction; immediate ones override
                n_s      = PW'(i_start_index);
                n_e      = PW'(size_m1);
                n_rv     = i_run_value;
                n_acc    = '0;
                n_answer = '0;
                n_status = bre_pkg::ST_OK;
                n_kind   = bre_pkg::K_READ;
                if (start) begin
                    n_state = S_WALK;
                    unique case (i_operation)
                        bre_pkg::OP_GET, bre_pkg::OP_SET, bre_pkg::OP_CLR: begin
                            n_e = PW'(i_start_index);
                            if (i_operation == bre_pkg::OP_SET) begin
                                n_kind = bre_pkg::K_SET;
                            end else if (i_operation == bre_pkg::OP_CLR) begin
                                n_kind = bre_pkg::K_CLR;
                            end
                            if (pos_bad) begin
                                n_state  = S_IDLE;
                                n_done   = 1'b1;
                                n_status = bre_pkg::ST_BAD;
                            end
                        end
                        bre_pkg::OP_RANGE_SET, bre_pkg::OP_RANGE_CLR,
                        bre_pkg::OP_RANGE_CNT: begin
                            n_e = PW'(i_stop_index);
                            if (i_operation == bre_pkg::OP_RANGE_SET) begin
                                n_kind = bre_pkg::K_SET;
                            end else if (i_operation == bre_pkg::OP_RANGE_CLR) begin
                                n_kind = bre_pkg::K_CLR;
                            end
                            if (range_bad) begin
                                n_state  = S_IDLE;
                                n_done   = 1'b1;
                                n_status = bre_pkg::ST_BAD;
                            end
                        end
                        bre_pkg::OP_RUN_LEN: begin
                            n_kind = bre_pkg::K_RUN;
                            if (pos_bad) begin
                                n_state  = S_IDLE;
                                n_done   = 1'b1;
                                n_status = bre_pkg::ST_BAD;
                            end
                        end
                        bre_pkg::OP_COMPLEMENT, bre_pkg::OP_CLEAR_ALL,
                        bre_pkg::OP_FILL_ALL: begin
                            n_s = '0;
                            if (i_operation == bre_pkg::OP_COMPLEMENT) begin
                                n_kind = bre_pkg::K_INV;
                            end else if (i_operation == bre_pkg::OP_CLEAR_ALL) begin
                                n_kind = bre_pkg::K_CLR;
                            end else begin
                                n_kind = bre_pkg::K_SET;
                            end
                        end
                        bre_pkg::OP_NEXT_SET: begin
                            n_kind = bre_pkg::K_NEXT;
                            n_s    = PW'(cur_pos);
                            // cursor already past the last position in use
                            if (32'(cur_pos) > 32'(size_m1)) begin
                                n_state  = S_IDLE;
                                n_done   = 1'b1;
                                n_status = bre_pkg::ST_NONE;
                                if (r_cw < words) begin
                                    n_cw = words;
                                    n_cb = '0;
                                end
                            end
                        end
                        bre_pkg::OP_CURSOR_RST: begin
                            n_state = S_IDLE;
                            n_done  = 1'b1;
                            n_cw    = '0;
                            n_cb    = '0;
                        end
                        default: begin
                            n_state  = S_IDLE;
                            n_done   = 1'b1;
                            n_status = bre_pkg::ST_BAD;
                        end
                    endcase
                end
                n_w       = n_s[PW-1:5];
                ram_raddr = n_s[PW-1:5];
            end
            S_WALK: begin
                // read-modify-write of word r_w while word r_w + 1 is fetched
                ram_we    = (r_kind == bre_pkg::K_SET) || (r_kind == bre_pkg::K_CLR) ||
                            (r_kind == bre_pkg::K_INV);
                ram_wdata = alu_res.new_word;
                n_ones    = r_ones + CW'(alu_res.ones_after) - CW'(alu_res.ones_before);
                n_w       = r_w + AW'(1);
                if (r_kind == bre_pkg::K_RUN) begin
                    n_acc = r_acc + bre_pkg::ANS_W'(run_add);
                end else begin
                    n_acc = r_acc + bre_pkg::ANS_W'(alu_res.ones_before);
                end
                if (r_kind == bre_pkg::K_NEXT && alu_res.hit) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_answer = bre_pkg::ANS_W'({r_w, alu_res.hit_idx});
                    n_cw     = hit_next[PW:5];
                    n_cb     = hit_next[4:0];
                end else if (r_kind == bre_pkg::K_RUN && alu_res.hit) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_answer = n_acc;
                end else if (w_last) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    if (r_kind == bre_pkg::K_NEXT) begin
                        n_status = bre_pkg::ST_NONE;
                        n_answer = '0;
                        n_cw     = words;
                        n_cb     = '0;
                    end else if (r_kind == bre_pkg::K_READ || r_kind == bre_pkg::K_RUN) begin
                        n_answer = n_acc;
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase

        // config write clears the store, the count and the cursor
        if (i_cfg_we) begin
            n_cfg   = i_cfg_data;
            n_state = S_CLEAR;
            n_w     = '0;
            n_ones  = '0;
            n_cw    = '0;
            n_cb    = '0;
            n_done  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cfg   <= bre_pkg::CFG_RESET;
            r_ones  <= '0;
            r_cw    <= '0;
            r_cb    <= '0;
            r_w     <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cfg   <= n_cfg;
            r_ones  <= n_ones;
            r_cw    <= n_cw;
            r_cb    <= n_cb;
            r_w     <= n_w;
            r_done  <= n_done;
        end
    end

    // transaction payload
    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_s      <= n_s;
        r_e      <= n_e;
        r_rv     <= n_rv;
        r_acc    <= n_acc;
        r_answer <= n_answer;
        r_status <= n_status;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_answer     = r_answer;
    assign o_status     = r_status;
    assign o_ones_total = r_ones;

    `BRE_ASSERT_NEXT(a_accept_acts, start && !busy && !i_cfg_we, busy || o_done)
    `BRE_ASSERT_NOW(a_write_owner, ram_we, r_state == S_WALK || r_state == S_CLEAR)
    `BRE_ASSERT_NOW(a_walk_bound, r_state == S_WALK, r_w <= r_e[PW-1:5])
    `BRE_ASSERT_NOW(a_status_code, o_done, o_status <= bre_pkg::ST_NONE)
endmodule
`default_nettype wire
